/* src/vector3_arithmetic_unit_core_defines.svh */
// Assertion macros for the checker file of the vector unit.
// No dependencies; included by bare file name.
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Check a property on every edge outside reset.
`define VAU_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vector unit check failed");

// Check a property on every edge, reset included.
`define VAU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vector unit check failed");

`endif

/* src/vau_pkg.sv */
// Shared types and constants of the vector unit: stream widths, operation codes.
// No dependencies.
package vau_pkg;

    localparam int FIELD_W      = 32;
    localparam int FUNC_W       = 4;
    localparam int IN_FIELDS_W  = FUNC_W + 7 * FIELD_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * FIELD_W + 2;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_OVF_BIT  = 4 * FIELD_W;
    localparam int OUT_ZL_BIT   = 4 * FIELD_W + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 4'd0,
        FN_SUB    = 4'd1,
        FN_SCALE  = 4'd2,
        FN_DOT    = 4'd3,
        FN_SQLEN  = 4'd4,
        FN_LENGTH = 4'd5,
        FN_NORM   = 4'd6,
        FN_NEGATE = 4'd7,
        FN_CROSS  = 4'd8
    } func_t;

endpackage

/* src/vector3_arithmetic_unit_core.sv */
// Three-component vector unit in signed fixed point: add, sub, scale, dot,
// squared length, length, normalize, negate, cross. Uses vau_pkg, vau_isqrt, vau_div.
//
// Usage:
//   Input beats arrive on s_axis_*, one operation per beat; results leave on m_axis_*,
//   one beat per input beat, in order. Every operation runs the full pipeline from
//   accept to m_axis_tvalid. A new beat is taken every cycle while the output is not
//   stalled. Stages: input register, six multipliers, product sums, rounding and
//   saturation, COMP_WIDTH square-root stages (one root bit each), FRAC_BITS + 1
//   divider stages (one quotient bit each, three lanes), output register.
//   Reset clears every valid bit; the output goes quiet until new beats pass through.
//   When the receiver holds m_axis_tready low with a beat waiting, the whole pipeline
//   holds and s_axis_tready drops in the same cycle; nothing is lost or repeated.
//   Components use the low COMP_WIDTH bits of each field, sign-extended; results are
//   sign-extended to 32 bits.
module vector3_arithmetic_unit_core
    import vau_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // func[3:0], a_x, a_y, a_z, b_x, b_y, b_z, factor (32 bits each), zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // r_x, r_y, r_z, scalar (32 bits each), overflow, zero_length, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int C  = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * C;
    localparam int WW = PW + 2;
    localparam int ZW = WW + 1;
    localparam int QW = F + 1;

    localparam logic signed [ZW-1:0] CMAX_Z = $signed({{(ZW-C+1){1'b0}}, {(C-1){1'b1}}});
    localparam logic signed [ZW-1:0] CMIN_Z = ~CMAX_Z;
    localparam logic [ZW-1:0]        HALF_Z = (ZW'(1) << F) >> 1;

    typedef struct packed {
        logic signed [C-1:0] val;
        logic                ovf;
    } sat_t;

    typedef struct packed {
        func_t              func;
        logic [2:0][C-1:0]  r;
        logic [C-1:0]       s;
        logic               ovf;
        logic [2:0][C-1:0]  a;
    } rec_t;

    // clamp to the signed COMP_WIDTH range
    function automatic sat_t sat_comp(input logic signed [ZW-1:0] x);
        sat_t res;
        if (x > CMAX_Z)
        begin
            res.val = CMAX_Z[C-1:0];
            res.ovf = 1'b1;
        end
        else if (x < CMIN_Z)
        begin
            res.val = CMIN_Z[C-1:0];
            res.ovf = 1'b1;
        end
        else
        begin
            res.val = x[C-1:0];
            res.ovf = 1'b0;
        end
        return res;
    endfunction

    // round half up from 2F to F fraction bits, then clamp
    function automatic sat_t narrow(input logic signed [ZW-1:0] x);
        logic signed [ZW-1:0] y;
        y = (x + $signed(HALF_Z)) >>> F;
        return sat_comp(y);
    endfunction

    // Global advance: the pipeline moves whenever the output slot is free or taken.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- input unpack ----------------
    logic signed [C-1:0] in_comp [7];
    for (genvar k = 0; k < 7; k++) begin : g_unpack
        assign in_comp[k] = $signed(s_axis_tdata[FUNC_W + k*FIELD_W +: C]);
    end

    // ---------------- stage 0: input register ----------------
    logic                p0_valid_reg;
    func_t               p0_func_reg;
    logic signed [C-1:0] p0_a_reg [3];
    logic signed [C-1:0] p0_b_reg [3];
    logic signed [C-1:0] p0_f_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_func_reg <= func_t'(s_axis_tdata[FUNC_W-1:0]);
            for (int i = 0; i < 3; i++)
            begin
                p0_a_reg[i] <= in_comp[i];
                p0_b_reg[i] <= in_comp[3+i];
            end
            p0_f_reg <= in_comp[6];
        end
    end

    // ---------------- stage 1: multipliers, add/sub/negate ----------------
    logic signed [PW-1:0] prod_next [6];
    sat_t                 simp_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_mul
        localparam int NX = (i + 1) % 3;
        localparam int PV = (i + 2) % 3;
        logic signed [C-1:0] opx;
        logic signed [C-1:0] opy;
        logic signed [C:0]   smp;

        always_comb
        begin
            opx = p0_a_reg[i];
            opy = p0_a_reg[i];
            unique case (p0_func_reg)
                FN_SCALE: opy = p0_f_reg;
                FN_DOT:   opy = p0_b_reg[i];
                FN_CROSS:
                begin
                    opx = p0_a_reg[NX];
                    opy = p0_b_reg[PV];
                end
                default: ;
            endcase
        end

        // cross terms: lane i pairs with the opposite product in i+3
        assign prod_next[i]   = opx * opy;
        assign prod_next[i+3] = p0_a_reg[PV] * p0_b_reg[NX];

        always_comb
        begin
            case (p0_func_reg)
                FN_ADD:    smp = (C+1)'(p0_a_reg[i]) + (C+1)'(p0_b_reg[i]);
                FN_SUB:    smp = (C+1)'(p0_a_reg[i]) - (C+1)'(p0_b_reg[i]);
                FN_NEGATE: smp = -(C+1)'(p0_a_reg[i]);
                default:   smp = '0;
            endcase
        end

        assign simp_next[i] = sat_comp(ZW'(smp));
    end

    logic                 p1_valid_reg;
    func_t                p1_func_reg;
    logic signed [C-1:0]  p1_a_reg [3];
    logic signed [PW-1:0] p1_prod_reg [6];
    sat_t                 p1_simp_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_func_reg <= p0_func_reg;
            for (int i = 0; i < 3; i++)
            begin
                p1_a_reg[i]    <= p0_a_reg[i];
                p1_simp_reg[i] <= simp_next[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                p1_prod_reg[i] <= prod_next[i];
            end
        end
    end

    // ---------------- stage 2: cross differences and three-term sum ----------------
    logic signed [PW:0]   w_next [3];
    logic signed [WW-1:0] sum_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (p1_func_reg == FN_CROSS)
            begin
                w_next[i] = (PW+1)'(p1_prod_reg[i]) - (PW+1)'(p1_prod_reg[i+3]);
            end
            else
            begin
                w_next[i] = (PW+1)'(p1_prod_reg[i]);
            end
        end
        sum_next = WW'(p1_prod_reg[0]) + WW'(p1_prod_reg[1]) + WW'(p1_prod_reg[2]);
    end

    logic                 p2_valid_reg;
    func_t                p2_func_reg;
    logic signed [C-1:0]  p2_a_reg [3];
    logic signed [PW:0]   p2_w_reg [3];
    logic signed [WW-1:0] p2_sum_reg;
    sat_t                 p2_simp_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_func_reg <= p1_func_reg;
            p2_sum_reg  <= sum_next;
            for (int i = 0; i < 3; i++)
            begin
                p2_a_reg[i]    <= p1_a_reg[i];
                p2_w_reg[i]    <= w_next[i];
                p2_simp_reg[i] <= p1_simp_reg[i];
            end
        end
    end

    // ---------------- stage 3: round, saturate, pick the result ----------------
    sat_t          rn [3];
    sat_t          sn;
    rec_t          rec_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rn[i] = narrow(ZW'(p2_w_reg[i]));
        end
        sn = narrow(ZW'(p2_sum_reg));

        rec_next      = '0;
        rec_next.func = p2_func_reg;
        for (int i = 0; i < 3; i++)
        begin
            rec_next.a[i] = p2_a_reg[i];
        end
        case (p2_func_reg) inside
            FN_ADD, FN_SUB, FN_NEGATE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rec_next.r[i] = p2_simp_reg[i].val;
                end
                rec_next.ovf = p2_simp_reg[0].ovf | p2_simp_reg[1].ovf | p2_simp_reg[2].ovf;
            end
            FN_SCALE, FN_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rec_next.r[i] = rn[i].val;
                end
                rec_next.ovf = rn[0].ovf | rn[1].ovf | rn[2].ovf;
            end
            FN_DOT, FN_SQLEN:
            begin
                rec_next.s   = sn.val;
                rec_next.ovf = sn.ovf;
            end
            default: ;
        endcase
    end

    logic          p3_valid_reg;
    rec_t          p3_rec_reg;
    logic [PW-1:0] p3_rad_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_rec_reg <= rec_next;
            // sum of squares is never negative, so the low bits are the radicand
            p3_rad_reg <= p2_sum_reg[PW-1:0];
        end
    end

    // ---------------- square root stages ----------------
    logic [C-1:0] sq_root;

    vau_isqrt #(
        .ROOT_W (C)
    ) u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (p3_rad_reg),
        .root     (sq_root)
    );

    logic [C-1:0] q_valid_reg;
    rec_t         q_rec_reg [C];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_rec_reg[0] <= p3_rec_reg;
            for (int k = 1; k < C; k++)
            begin
                q_rec_reg[k] <= q_rec_reg[k-1];
            end
        end
    end

    // ---------------- divider stages, one lane per component ----------------
    logic [QW-1:0] quo [3];
    logic [C-1:0]  div_len;

    for (genvar i = 0; i < 3; i++) begin : g_div
        logic [C-1:0] a_mag;
        logic [C-1:0] len_out;
        assign a_mag = q_rec_reg[C-1].a[i][C-1] ? (C'(0) - q_rec_reg[C-1].a[i])
                                                : q_rec_reg[C-1].a[i];
        vau_div #(
            .DIV_W (C),
            .QUO_W (QW)
        ) u_div (
            .clk         (clk),
            .en          (adv),
            .dividend    (a_mag),
            .divisor     (sq_root),
            .quotient    (quo[i]),
            .divisor_out (len_out)
        );
        if (i == 0) begin : g_len
            assign div_len = len_out;
        end
    end

    logic [QW-1:0] d_valid_reg;
    rec_t          d_rec_reg [QW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_rec_reg[0] <= q_rec_reg[C-1];
            for (int k = 1; k < QW; k++)
            begin
                d_rec_reg[k] <= d_rec_reg[k-1];
            end
        end
    end

    // ---------------- final select: length and normalize ----------------
    rec_t                 fin;
    sat_t                 len_sat;
    sat_t                 qsat [3];
    logic signed [ZW-1:0] qs [3];
    logic [2:0][C-1:0]    r_next;
    logic [C-1:0]         s_next;
    logic                 ovf_next;
    logic                 zl_next;

    always_comb
    begin
        fin     = d_rec_reg[QW-1];
        len_sat = sat_comp($signed(ZW'({1'b0, div_len})));
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = $signed(ZW'({1'b0, quo[i]}));
            if (fin.a[i][C-1])
            begin
                qs[i] = -qs[i];
            end
            qsat[i] = sat_comp(qs[i]);
        end

        r_next   = fin.r;
        s_next   = fin.s;
        ovf_next = fin.ovf;
        zl_next  = 1'b0;
        case (fin.func) inside
            FN_LENGTH:
            begin
                r_next   = '0;
                s_next   = len_sat.val;
                ovf_next = len_sat.ovf;
            end
            FN_NORM:
            begin
                if (div_len == '0)
                begin
                    r_next   = '0;
                    s_next   = '0;
                    ovf_next = 1'b0;
                    zl_next  = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        r_next[i] = qsat[i].val;
                    end
                    s_next   = len_sat.val;
                    ovf_next = len_sat.ovf | qsat[0].ovf | qsat[1].ovf | qsat[2].ovf;
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    logic                out_valid_reg;
    logic signed [C-1:0] out_r_reg [3];
    logic signed [C-1:0] out_s_reg;
    logic                out_ovf_reg;
    logic                out_zl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_r_reg[i] <= r_next[i];
            end
            out_s_reg   <= s_next;
            out_ovf_reg <= ovf_next;
            out_zl_reg  <= zl_next;
        end
    end

    // valid bits travel with the data and are the only state reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            q_valid_reg   <= '0;
            d_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg  <= s_axis_tvalid;
            p1_valid_reg  <= p0_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            q_valid_reg   <= C'({q_valid_reg, p3_valid_reg});
            d_valid_reg   <= QW'({d_valid_reg, q_valid_reg[C-1]});
            out_valid_reg <= d_valid_reg[QW-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
        out_zl_reg,
        out_ovf_reg,
        FIELD_W'(out_s_reg),
        FIELD_W'(out_r_reg[2]),
        FIELD_W'(out_r_reg[1]),
        FIELD_W'(out_r_reg[0])
    };

endmodule

/* src/vau_isqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// No dependencies.
module vau_isqrt #(
    parameter int ROOT_W = 32
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic [REM_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int POS = ROOT_W - 1 - k;
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [SH_W-1:0]     shifted;
        logic [SH_W-1:0]     trial;
        logic [SH_W-1:0]     diff;
        logic [REM_W-1:0]    rem_next;
        logic [ROOT_W-1:0]   root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign shifted = {rem_in, rad_in[2*POS+1 -: 2]};
        assign trial   = SH_W'({root_in, 2'b01});
        assign diff    = shifted - trial;

        always_comb
        begin
            if (shifted >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[REM_W-1:0];
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k] <= rad_in;
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

/* src/vau_div.sv */
// Pipelined restoring divider for one lane, one quotient bit per register stage.
// Quotient is (dividend * 2^(QUO_W-1)) / divisor, valid when dividend <= divisor.
module vau_div #(
    parameter int DIV_W = 32,
    parameter int QUO_W = 17
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic [QUO_W-1:0]  quotient,
    output logic [DIV_W-1:0]  divisor_out
);

    logic [DIV_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DIV_W-1:0] dsr_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [DIV_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DIV_W-1:0] dsr_in;
        logic             nbit;
        logic [DIV_W:0]   shifted;
        logic [DIV_W:0]   diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = {1'b0, dividend[DIV_W-1:1]};
            assign quo_in = '0;
            assign dsr_in = divisor;
            assign nbit   = dividend[0];
        end
        else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign dsr_in = dsr_reg[j-1];
            assign nbit   = 1'b0;
        end

        assign shifted = {rem_in, nbit};
        assign diff    = shifted - {1'b0, dsr_in};
        assign ge      = (shifted >= {1'b0, dsr_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                quo_reg[j] <= QUO_W'({quo_in, ge});
                dsr_reg[j] <= dsr_in;
            end
        end
    end

    assign quotient    = quo_reg[QUO_W-1];
    assign divisor_out = dsr_reg[QUO_W-1];

endmodule

/* src/vau_checker.sv */
// Port-level checks of the vector unit, bound to the top level.
// Uses vau_pkg and vector3_arithmetic_unit_core_defines.svh.
`include "vector3_arithmetic_unit_core_defines.svh"

module vau_checker
    import vau_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // hold a stalled result beat unchanged
    `VAU_ASSERT_RST(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // an empty output slot never back-pressures the input
    `VAU_ASSERT_RST(a_ready_when_empty, clk, rst_n, !m_axis_tvalid |-> s_axis_tready)

    // a zero-length normalize carries nothing else
    `VAU_ASSERT_RST(a_zero_len_clean, clk, rst_n, m_axis_tvalid && m_axis_tdata[OUT_ZL_BIT] |-> m_axis_tdata[OUT_OVF_BIT:0] == '0)

    // reset drops the output valid
    `VAU_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_axis_tvalid)

endmodule

bind vector3_arithmetic_unit_core vau_checker u_checker (.*);

/* tb/vector3_arithmetic_unit_core_test.sv */
// Testbench for the fixed-point three-component vector unit: random and directed beats,
// results predicted in-bench and compared field by field in order.
// Depends on vau_pkg and vector3_arithmetic_unit_core.
module vector3_arithmetic_unit_core_test;
    import vau_pkg::*;

    localparam int FRAC   = 16;
    localparam int LAT    = 32 + 16 + 5;
    localparam int WD_MAX = 20000;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] rx, ry, rz, sc;
        logic        ovf, zl;
    } vres_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // func[3:0], a_x, a_y, a_z, b_x, b_y, b_z, factor, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // r_x, r_y, r_z, scalar, overflow, zero_length, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    vres_t  expected_q[$];
    int     n_err;
    int     idle_cycles;
    bit     calm;   // no idling on either side while set

    vector3_arithmetic_unit_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0; #1;
        clk = 1'b1; #1;
    end

    // Clamp to the component range and flag the clip.
    function automatic longint clip(longint x, ref bit ovf);
        if (x > CMAX) begin ovf = 1; return CMAX; end
        if (x < CMIN) begin ovf = 1; return CMIN; end
        return x;
    endfunction

    // Round a Q32.32 sum to Q16.16 (half up), then clamp. Use 128 bits so nothing wraps.
    function automatic longint round_q(logic signed [127:0] p, ref bit ovf);
        logic signed [127:0] t;
        t = (p + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (t > CMAX) begin ovf = 1; return CMAX; end
        if (t < CMIN) begin ovf = 1; return CMIN; end
        return longint'(t);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Work out what the unit returns for one input beat.
    function automatic vres_t vector_result(logic [IN_DATA_W-1:0] d);
        logic [3:0]  fn;
        longint      a[3], b[3], f, r[3], s;
        logic signed [127:0] p;
        logic [63:0] mag, sumsq, len;
        bit          ovf, zl;
        vres_t       res;
        fn = d[3:0];
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(d[4 + 32*i +: 32]));
            b[i] = longint'($signed(d[100 + 32*i +: 32]));
            r[i] = 0;
        end
        f = longint'($signed(d[196 +: 32]));
        s = 0; ovf = 0; zl = 0;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (a[i] < 0) ? -a[i] : a[i];
            sumsq = sumsq + mag * mag;   // at most 3*2^62, fits in 64 bits unsigned
        end
        case (fn)
            FN_ADD:    for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i], ovf);
            FN_SUB:    for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i], ovf);
            FN_SCALE:  for (int i = 0; i < 3; i++) r[i] = round_q(128'(a[i] * f), ovf);
            FN_DOT:
            begin
                p = 128'(a[0]*b[0]) + 128'(a[1]*b[1]) + 128'(a[2]*b[2]);
                s = round_q(p, ovf);
            end
            FN_SQLEN:  s = round_q($signed({64'd0, sumsq}), ovf);
            FN_LENGTH, FN_NORM:
            begin
                len = root64(sumsq);
                if (fn == FN_NORM && len == 0)
                    zl = 1;
                else
                begin
                    s = clip(longint'(len), ovf);
                    if (fn == FN_NORM)
                        for (int i = 0; i < 3; i++)
                            r[i] = clip((a[i] * 65536) / longint'(len), ovf);
                end
            end
            FN_NEGATE: for (int i = 0; i < 3; i++) r[i] = clip(-a[i], ovf);
            FN_CROSS:
            begin
                r[0] = round_q(128'(a[1]*b[2]) - 128'(a[2]*b[1]), ovf);
                r[1] = round_q(128'(a[2]*b[0]) - 128'(a[0]*b[2]), ovf);
                r[2] = round_q(128'(a[0]*b[1]) - 128'(a[1]*b[0]), ovf);
            end
            default: ;
        endcase
        res.rx = r[0][31:0]; res.ry = r[1][31:0]; res.rz = r[2][31:0];
        res.sc = s[31:0]; res.ovf = ovf; res.zl = zl;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_err++;
    endtask

    // Sender: drive one beat, hold it until accepted. Valid stays high afterwards
    // so the next beat can follow directly; stop_sending drops it.
    task automatic send_beat(logic [3:0] fn, logic [31:0] ax, ay, az, bx, by, bz, fac);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[3:0] = fn;
        d[4 +: 32] = ax;  d[36 +: 32] = ay;  d[68 +: 32] = az;
        d[100 +: 32] = bx; d[132 +: 32] = by; d[164 +: 32] = bz;
        d[196 +: 32] = fac;
        while (!calm && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_q.push_back(vector_result(d));
        @(negedge clk);
    endtask

    // Drop valid so nothing further is offered.
    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(65536 * 4) - 65536 * 2;
            3: return 32'(int'($urandom_range(1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    // Result checker, sampled at the rising edge.
    always @(posedge clk)
    begin
        vres_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.rx = m_axis_tdata[31:0];  got.ry = m_axis_tdata[63:32];
            got.rz = m_axis_tdata[95:64]; got.sc = m_axis_tdata[127:96];
            got.ovf = m_axis_tdata[OUT_OVF_BIT];
            got.zl  = m_axis_tdata[OUT_ZL_BIT];
            if (expected_q.size() == 0)
                report("unexpected beat", got.rx, 32'h0);
            else
            begin
                want = expected_q.pop_front();
                if (got.rx != want.rx) report("r_x", got.rx, want.rx);
                if (got.ry != want.ry) report("r_y", got.ry, want.ry);
                if (got.rz != want.rz) report("r_z", got.rz, want.rz);
                if (got.sc != want.sc) report("scalar", got.sc, want.sc);
                if (got.ovf != want.ovf) report("overflow", 32'(got.ovf), 32'(want.ovf));
                if (got.zl != want.zl) report("zero_length", 32'(got.zl), 32'(want.zl));
            end
        end
    end

    // Receiver stalls: change ready at the falling edge.
    always @(negedge clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    // Watchdog: count cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed: field extremes, every operation, zero-length normalize, unknown codes.
    task automatic test_directed();
        send_beat(FN_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1, 32'hffff_ffff, 0, 0);
        send_beat(FN_SUB, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h1, 32'hffff_ffff, 0, 0);
        send_beat(FN_SCALE, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000,
                  0, 0, 0, 32'h8000_0000);
        send_beat(FN_SCALE, 32'h0002_0000, 32'hffff_0000, 32'h0000_8000,
                  0, 0, 0, 32'h0001_8000);
        send_beat(FN_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(FN_DOT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'hffff_0000, 32'h0001_0000, 32'h0000_0001, 0);
        send_beat(FN_SQLEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        send_beat(FN_SQLEN, 32'h0000_0001, 32'h0000_0100, 0, 0, 0, 0, 0);
        send_beat(FN_LENGTH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        send_beat(FN_LENGTH, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
        send_beat(FN_NORM, 0, 0, 0, 32'hffff_ffff, 0, 0, 32'hffff_ffff);
        send_beat(FN_NORM, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
        send_beat(FN_NORM, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 0, 0, 0, 0);
        send_beat(FN_NEGATE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        send_beat(FN_CROSS, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(FN_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0);
        for (int c = 9; c < 16; c++)
            send_beat(4'(c), 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff,
                      32'hffff_ffff, 1, 2, 3);
    endtask

    // Random: mostly valid codes, a few unknown ones.
    task automatic test_random(int n);
        logic [3:0] fn;
        for (int i = 0; i < n; i++)
        begin
            fn = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(8));
            send_beat(fn, rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    // Hold the sender until the pipeline has drained, then send further random beats.
    task automatic test_drain_pause();
        stop_sending();
        while (expected_q.size() != 0) @(negedge clk);
        test_random(40);
    endtask

    // Back-to-back beats with the receiver always ready.
    task automatic test_full_rate();
        calm = 1;
        test_random(200);
        calm = 0;
    endtask

    initial
    begin
        n_err = 0;
        idle_cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(400);
        test_drain_pause();
        test_full_rate();
        test_random(560);

        stop_sending();
        while (expected_q.size() != 0) @(negedge clk);
        repeat (LAT + 10) @(negedge clk);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
